/* sv/jfshp_pkg.sv */
// Package with the item types, codes and control store for the JPEG frame/scan header parser.
`timescale 1ns / 1ps

package jfshp_pkg;

    localparam int unsigned COMPONENTS = 3;
    localparam int unsigned BLOCK_SIZE = 8;

    // Segment kinds.
    localparam logic KIND_FRAME = 1'b0;
    localparam logic KIND_SCAN  = 1'b1;

    // Result status codes.
    localparam logic [2:0] STAT_OK          = 3'd0;
    localparam logic [2:0] STAT_BAD_COUNT   = 3'd1;
    localparam logic [2:0] STAT_BAD_QUANT   = 3'd2;
    localparam logic [2:0] STAT_BAD_HUFF    = 3'd3;
    localparam logic [2:0] STAT_ZERO_FACTOR = 3'd4;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       segment_start;
        logic       segment_kind;
    } t_header_item;

    typedef struct packed {
        logic        done_kind;
        logic [2:0]  status;
        logic        layer;
        logic [15:0] image_height;
        logic [15:0] image_width;
        logic [13:0] mcu_columns;
        logic [13:0] mcu_rows;
        logic [23:0] sampling_factors;
        logic [2:0]  quant_table_ids;
        logic [5:0]  huffman_table_ids;
    } t_result_item;

    // Micro-operations executed for one header byte.
    typedef enum logic [3:0] {
        UOP_NOP,
        UOP_HEIGHT_HI,
        UOP_HEIGHT_LO,
        UOP_WIDTH_HI,
        UOP_WIDTH_LO,
        UOP_COUNT,
        UOP_FACTOR,
        UOP_QUANT,
        UOP_HUFF,
        UOP_SCAN_END
    } t_uop;

    typedef struct packed {
        t_uop       op;
        logic [1:0] comp;
        logic       last;   // Last byte of a frame header: branch to the MCU divide routine.
    } t_ctrl_word;

    // Control store, addressed by segment kind and byte position.
    function automatic t_ctrl_word ucode_rom(input logic kind, input logic [4:0] pos);
        t_ctrl_word cw;
        cw = '{op: UOP_NOP, comp: 2'd0, last: 1'b0};
        if (kind == KIND_FRAME) begin
            case (pos)
                5'd3:    cw.op = UOP_HEIGHT_HI;
                5'd4:    cw.op = UOP_HEIGHT_LO;
                5'd5:    cw.op = UOP_WIDTH_HI;
                5'd6:    cw.op = UOP_WIDTH_LO;
                5'd7:    cw.op = UOP_COUNT;
                5'd9:    cw = '{op: UOP_FACTOR, comp: 2'd0, last: 1'b0};
                5'd10:   cw = '{op: UOP_QUANT,  comp: 2'd0, last: 1'b0};
                5'd12:   cw = '{op: UOP_FACTOR, comp: 2'd1, last: 1'b0};
                5'd13:   cw = '{op: UOP_QUANT,  comp: 2'd1, last: 1'b0};
                5'd15:   cw = '{op: UOP_FACTOR, comp: 2'd2, last: 1'b0};
                5'd16:   cw = '{op: UOP_QUANT,  comp: 2'd2, last: 1'b1};
                default: cw.op = UOP_NOP;
            endcase
        end else begin
            case (pos)
                5'd2:    cw.op = UOP_COUNT;
                5'd4:    cw = '{op: UOP_HUFF, comp: 2'd0, last: 1'b0};
                5'd6:    cw = '{op: UOP_HUFF, comp: 2'd1, last: 1'b0};
                5'd8:    cw = '{op: UOP_HUFF, comp: 2'd2, last: 1'b0};
                5'd11:   cw.op = UOP_SCAN_END;
                default: cw.op = UOP_NOP;
            endcase
        end
        return cw;
    endfunction

endpackage

/* sv/jpeg_frame_scan_header_parser.sv */
// Top level of the JPEG frame/scan header parser: microcoded byte sequencer and MCU divider.
// A scan result or an error result is in the output register in the cycle after its byte.
// A good frame header runs a 14-step divide, then its result is loaded once the output is free.
// Throughput: one header byte per cycle; the input stalls after a good frame header during
// the 14 divide steps and the load, while the restoring dividers compute both MCU counts,
// and while a result waits.
// Reset (i_rst_n low, synchronous) clears the control and parsing registers and leaves the
// parser waiting for a segment start.
`timescale 1ns / 1ps

module jpeg_frame_scan_header_parser import jfshp_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    output logic         o_in_ready,
    input  t_header_item i_in_data,
    output logic         o_out_valid,
    input  logic         i_out_ready,
    output t_result_item o_out_data,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic         i_cfg_data
);

    localparam logic [3:0] DIV_STEPS = 4'd14;

    typedef enum logic [2:0] {
        S_RUN  = 3'b001,
        S_DIV  = 3'b010,
        S_LOAD = 3'b100
    } t_seq_state;

    t_seq_state   r_state, n_state;
    logic         r_kind, n_kind;
    logic [4:0]   r_pos, n_pos;
    logic         r_skip, n_skip;
    logic         r_halted, n_halted;
    logic [15:0]  r_height, n_height;
    logic [15:0]  r_width, n_width;
    logic [23:0]  r_factors, n_factors;
    logic [2:0]   r_quant, n_quant;
    logic [5:0]   r_huff, n_huff;
    logic [7:0]   r_base0, n_base0;
    logic         r_residual;
    logic         r_out_valid;
    t_result_item r_out_data, n_out_data;
    logic [3:0]   r_div_cnt;
    logic [13:0]  r_col_quo, n_col_quo;
    logic [3:0]   r_col_rem, n_col_rem;
    logic [13:0]  r_row_quo, n_row_quo;
    logic [3:0]   r_row_rem, n_row_rem;

    logic         in_fire;
    logic         cur_kind;
    logic [4:0]   cur_pos;
    logic         cur_skip;
    logic         cur_halted;
    t_ctrl_word   cw;
    logic [7:0]   b;
    logic         emit;
    logic [2:0]   emit_status;
    logic         start_div;
    logic         load_div;
    logic [3:0]   hf;
    logic [3:0]   vf;
    logic [4:0]   col_trial;
    logic [4:0]   row_trial;
    logic         col_ge;
    logic         row_ge;

    assign o_in_ready  = (r_state == S_RUN) && (!r_out_valid || i_out_ready);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    assign in_fire    = i_in_valid && o_in_ready;
    assign b          = i_in_data.data_byte;
    assign cur_kind   = i_in_data.segment_start ? i_in_data.segment_kind : r_kind;
    assign cur_pos    = i_in_data.segment_start ? 5'd0 : r_pos;
    assign cur_skip   = i_in_data.segment_start ? 1'b0 : r_skip;
    assign cur_halted = i_in_data.segment_start ? 1'b0 : r_halted;
    assign cw         = ucode_rom(cur_kind, cur_pos);

    assign hf = r_base0[7:4];
    assign vf = r_base0[3:0];

    // Byte execution: one control word per accepted byte.
    always_comb begin
        n_kind      = r_kind;
        n_pos       = r_pos;
        n_skip      = r_skip;
        n_halted    = r_halted;
        n_height    = r_height;
        n_width     = r_width;
        n_factors   = r_factors;
        n_quant     = r_quant;
        n_huff      = r_huff;
        n_base0     = r_base0;
        emit        = 1'b0;
        emit_status = STAT_OK;
        start_div   = 1'b0;
        if (in_fire) begin
            n_kind   = cur_kind;
            n_pos    = cur_pos;
            n_skip   = cur_skip;
            n_halted = cur_halted;
            if (!cur_halted) begin
                if (cur_skip) begin
                    n_skip = 1'b0;
                end else begin
                    n_pos = cur_pos + 5'd1;
                    case (cw.op)
                        UOP_HEIGHT_HI: begin
                            n_height[15:8] = b;
                            n_skip         = (b == 8'hFF);
                        end
                        UOP_HEIGHT_LO: begin
                            n_height[7:0] = b;
                            n_skip        = (b == 8'hFF);
                        end
                        UOP_WIDTH_HI: begin
                            n_width[15:8] = b;
                            n_skip        = (b == 8'hFF);
                        end
                        UOP_WIDTH_LO: begin
                            n_width[7:0] = b;
                            n_skip       = (b == 8'hFF);
                        end
                        UOP_COUNT: begin
                            if (b != 8'(COMPONENTS)) begin
                                emit        = 1'b1;
                                emit_status = STAT_BAD_COUNT;
                            end
                        end
                        UOP_FACTOR: begin
                            case (cw.comp)
                                2'd0: begin
                                    n_factors[7:0] = b;
                                    if (!r_residual) begin
                                        n_base0 = b;
                                    end
                                end
                                2'd1:    n_factors[15:8]  = b;
                                default: n_factors[23:16] = b;
                            endcase
                        end
                        UOP_QUANT: begin
                            if (b[7:1] != 7'd0) begin
                                emit        = 1'b1;
                                emit_status = STAT_BAD_QUANT;
                            end else begin
                                n_quant[cw.comp] = b[0];
                                if (cw.last) begin
                                    if (n_base0[7:4] == 4'd0 || n_base0[3:0] == 4'd0) begin
                                        emit        = 1'b1;
                                        emit_status = STAT_ZERO_FACTOR;
                                    end else begin
                                        start_div = 1'b1;
                                    end
                                end
                            end
                        end
                        UOP_HUFF: begin
                            if (b[7:5] != 3'd0 || b[3:1] != 3'd0) begin
                                emit        = 1'b1;
                                emit_status = STAT_BAD_HUFF;
                            end else begin
                                n_huff[{cw.comp, 1'b0} +: 2] = {b[0], b[4]};
                            end
                        end
                        UOP_SCAN_END: begin
                            emit = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                    if (emit || start_div) begin
                        n_halted = 1'b1;
                    end
                end
            end
        end
    end

    // One restoring step per cycle for both MCU counts.
    assign col_trial = {r_col_rem, r_col_quo[13]};
    assign row_trial = {r_row_rem, r_row_quo[13]};
    assign col_ge    = col_trial >= {1'b0, hf};
    assign row_ge    = row_trial >= {1'b0, vf};

    always_comb begin
        n_col_quo = r_col_quo;
        n_col_rem = r_col_rem;
        n_row_quo = r_row_quo;
        n_row_rem = r_row_rem;
        if (start_div) begin
            // Dividends are ceil(dim / 8) + factor - 1, giving a rounded-up quotient.
            n_col_quo = {1'b0, r_width[15:3]} + 14'(|r_width[2:0])
                        + 14'(n_base0[7:4]) - 14'd1;
            n_row_quo = {1'b0, r_height[15:3]} + 14'(|r_height[2:0])
                        + 14'(n_base0[3:0]) - 14'd1;
            n_col_rem = 4'd0;
            n_row_rem = 4'd0;
        end else if (r_state == S_DIV) begin
            n_col_quo = {r_col_quo[12:0], col_ge};
            n_col_rem = col_ge ? 4'(col_trial - {1'b0, hf}) : col_trial[3:0];
            n_row_quo = {r_row_quo[12:0], row_ge};
            n_row_rem = row_ge ? 4'(row_trial - {1'b0, vf}) : row_trial[3:0];
        end
    end

    assign load_div = (r_state == S_LOAD) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_RUN: begin
                if (start_div) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (r_div_cnt == 4'd1) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                if (load_div) begin
                    n_state = S_RUN;
                end
            end
            default: n_state = S_RUN;
        endcase
    end

    always_comb begin
        n_out_data = r_out_data;
        if (emit) begin
            n_out_data = '{done_kind: n_kind, status: emit_status, layer: r_residual,
                           image_height: n_height, image_width: n_width,
                           mcu_columns: 14'd0, mcu_rows: 14'd0,
                           sampling_factors: n_factors, quant_table_ids: n_quant,
                           huffman_table_ids: n_huff};
        end else if (load_div) begin
            n_out_data = '{done_kind: r_kind, status: STAT_OK, layer: r_residual,
                           image_height: r_height, image_width: r_width,
                           mcu_columns: r_col_quo, mcu_rows: r_row_quo,
                           sampling_factors: r_factors, quant_table_ids: r_quant,
                           huffman_table_ids: r_huff};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_RUN;
            r_kind      <= KIND_FRAME;
            r_pos       <= 5'd0;
            r_skip      <= 1'b0;
            r_halted    <= 1'b1;
            r_height    <= 16'd0;
            r_width     <= 16'd0;
            r_factors   <= 24'd0;
            r_quant     <= 3'd0;
            r_huff      <= 6'd0;
            r_base0     <= 8'd0;
            r_residual  <= 1'b0;
            r_out_valid <= 1'b0;
            r_div_cnt   <= 4'd0;
        end else begin
            r_state  <= n_state;
            r_kind   <= n_kind;
            r_pos    <= n_pos;
            r_skip   <= n_skip;
            r_halted <= n_halted;
            r_height <= n_height;
            r_width  <= n_width;
            r_factors <= n_factors;
            r_quant  <= n_quant;
            r_huff   <= n_huff;
            r_base0  <= n_base0;
            if (i_cfg_valid) begin
                r_residual <= i_cfg_data;
            end
            if (emit || load_div) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (start_div) begin
                r_div_cnt <= DIV_STEPS;
            end else if (r_state == S_DIV) begin
                r_div_cnt <= r_div_cnt - 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
        r_col_quo  <= n_col_quo;
        r_col_rem  <= n_col_rem;
        r_row_quo  <= n_row_quo;
        r_row_rem  <= n_row_rem;
    end

`ifndef NO_ASSERTIONS
    a_no_input_while_dividing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_RUN) |-> !o_in_ready)
        else $error("input accepted while the MCU divide is in progress");

    a_divide_only_for_frames: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_kind == KIND_FRAME && r_halted && r_div_cnt != 4'd0))
        else $error("divider running outside a finished frame header");

    a_divisors_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (hf != 4'd0 && vf != 4'd0))
        else $error("divider running with a zero sampling factor");

    a_result_registered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit || load_div) |=> o_out_valid)
        else $error("result transaction was not presented");

    a_single_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(emit && load_div))
        else $error("byte result and divide result loaded together");
`endif

endmodule

/* dv/jfshp_result_checker.sv */
// Checker for the JPEG frame/scan header parser: predicts results from accepted bytes and compares.
`timescale 1ns / 1ps

module jfshp_result_checker import jfshp_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    input  logic         i_in_ready,
    input  t_header_item i_in_data,
    input  logic         i_out_valid,
    input  logic         i_out_ready,
    input  t_result_item i_out_data,
    input  logic         i_cfg_valid,
    input  logic         i_cfg_ready,
    input  logic         i_cfg_data,
    output int           o_error_count,
    output int           o_pending_results,
    output int           o_results_checked,
    output logic [7:0]   o_status_seen
);

    // Byte positions within the segment payload, counted after skipped bytes.
    localparam logic [4:0] FRM_HEIGHT_HI  = 5'd3;
    localparam logic [4:0] FRM_HEIGHT_LO  = 5'd4;
    localparam logic [4:0] FRM_WIDTH_HI   = 5'd5;
    localparam logic [4:0] FRM_WIDTH_LO   = 5'd6;
    localparam logic [4:0] FRM_COUNT      = 5'd7;
    localparam logic [4:0] FRM_LAST       = 5'd16;
    localparam logic [4:0] SCN_COUNT      = 5'd2;
    localparam logic [4:0] SCN_LAST_TABLE = 5'd8;
    localparam logic [4:0] SCN_LAST       = 5'd11;

    // Parser state as the checker sees it.
    logic        seg_kind;
    logic [4:0]  seg_pos;
    logic        drop_next;
    logic        parked;
    logic [15:0] cur_height;
    logic [15:0] cur_width;
    logic [23:0] cur_factors;
    logic [2:0]  cur_quant_ids;
    logic [5:0]  cur_huff_ids;
    logic [7:0]  base_factor0;
    logic        residual;

    t_result_item expected_results[$];

    function automatic int unsigned div_round_up(input int unsigned n, input int unsigned d);
        return (n + d - 1) / d;
    endfunction

    task automatic post_result(input logic [2:0] st, input int unsigned cols,
                               input int unsigned rows);
        t_result_item r;
        r.done_kind         = seg_kind;
        r.status            = st;
        r.layer             = residual;
        r.image_height      = cur_height;
        r.image_width       = cur_width;
        r.mcu_columns       = cols[13:0];
        r.mcu_rows          = rows[13:0];
        r.sampling_factors  = cur_factors;
        r.quant_table_ids   = cur_quant_ids;
        r.huffman_table_ids = cur_huff_ids;
        expected_results.push_back(r);
        parked = 1'b1;
    endtask

    task automatic predict_header_byte(input t_header_item it);
        logic [7:0]  b;
        int unsigned rel;
        int unsigned comp;
        int unsigned hf;
        int unsigned vf;
        b = it.data_byte;
        if (it.segment_start) begin
            seg_kind  = it.segment_kind;
            seg_pos   = '0;
            drop_next = 1'b0;
            parked    = 1'b0;
        end
        if (!parked) begin
            if (drop_next) begin
                // The byte after a 0xFF in the dimensions is dropped without advancing.
                drop_next = 1'b0;
            end else begin
                if (seg_kind == KIND_FRAME) begin
                    if (seg_pos >= FRM_HEIGHT_HI && seg_pos <= FRM_WIDTH_LO) begin
                        case (seg_pos)
                            FRM_HEIGHT_HI: cur_height[15:8] = b;
                            FRM_HEIGHT_LO: cur_height[7:0]  = b;
                            FRM_WIDTH_HI:  cur_width[15:8]  = b;
                            default:       cur_width[7:0]   = b;
                        endcase
                        if (b == 8'hFF) drop_next = 1'b1;
                    end else if (seg_pos == FRM_COUNT) begin
                        if (b != COMPONENTS) post_result(STAT_BAD_COUNT, 0, 0);
                    end else if (seg_pos > FRM_COUNT && seg_pos <= FRM_LAST) begin
                        rel  = seg_pos - FRM_COUNT - 1;
                        comp = rel / 3;
                        if (rel % 3 == 1) begin
                            cur_factors[8*comp +: 8] = b;
                            if (comp == 0 && !residual) base_factor0 = b;
                        end else if (rel % 3 == 2) begin
                            if (b > 1) post_result(STAT_BAD_QUANT, 0, 0);
                            else cur_quant_ids[comp] = b[0];
                        end
                        if (seg_pos == FRM_LAST && !parked) begin
                            // MCU counts always divide by the last base layer factor.
                            hf = base_factor0[7:4];
                            vf = base_factor0[3:0];
                            if (hf == 0 || vf == 0) begin
                                post_result(STAT_ZERO_FACTOR, 0, 0);
                            end else begin
                                post_result(STAT_OK,
                                    div_round_up(div_round_up(cur_width, BLOCK_SIZE), hf),
                                    div_round_up(div_round_up(cur_height, BLOCK_SIZE), vf));
                            end
                        end
                    end
                end else begin
                    if (seg_pos == SCN_COUNT) begin
                        if (b != COMPONENTS) post_result(STAT_BAD_COUNT, 0, 0);
                    end else if (seg_pos > SCN_COUNT && seg_pos <= SCN_LAST_TABLE) begin
                        rel  = seg_pos - SCN_COUNT - 1;
                        comp = rel / 2;
                        if (rel % 2 == 1) begin
                            if (b[7:4] > 1 || b[3:0] > 1) begin
                                post_result(STAT_BAD_HUFF, 0, 0);
                            end else begin
                                cur_huff_ids[2*comp]   = b[4];
                                cur_huff_ids[2*comp+1] = b[0];
                            end
                        end
                    end else if (seg_pos == SCN_LAST) begin
                        post_result(STAT_OK, 0, 0);
                    end
                end
                seg_pos = seg_pos + 5'd1;
            end
        end
    endtask

    function automatic int field_mismatch(input string name, input logic [31:0] exp_val,
                                          input logic [31:0] act_val);
        if (exp_val !== act_val) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
            return 1;
        end
        return 0;
    endfunction

    task automatic check_result(input t_result_item act);
        t_result_item ex;
        int           bad;
        if (expected_results.size() == 0) begin
            $error("result with no expectation waiting: status %0d kind %0d",
                   act.status, act.done_kind);
            o_error_count++;
        end else begin
            ex  = expected_results.pop_front();
            bad = 0;
            bad += field_mismatch("done_kind", ex.done_kind, act.done_kind);
            bad += field_mismatch("status", ex.status, act.status);
            bad += field_mismatch("layer", ex.layer, act.layer);
            bad += field_mismatch("image_height", ex.image_height, act.image_height);
            bad += field_mismatch("image_width", ex.image_width, act.image_width);
            bad += field_mismatch("mcu_columns", ex.mcu_columns, act.mcu_columns);
            bad += field_mismatch("mcu_rows", ex.mcu_rows, act.mcu_rows);
            bad += field_mismatch("sampling_factors", ex.sampling_factors,
                                  act.sampling_factors);
            bad += field_mismatch("quant_table_ids", ex.quant_table_ids, act.quant_table_ids);
            bad += field_mismatch("huffman_table_ids", ex.huffman_table_ids,
                                  act.huffman_table_ids);
            o_error_count += bad;
            o_status_seen[ex.status] = 1'b1;
        end
        o_results_checked++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            seg_kind          = KIND_FRAME;
            seg_pos           = '0;
            drop_next         = 1'b0;
            parked            = 1'b1;
            cur_height        = '0;
            cur_width         = '0;
            cur_factors       = '0;
            cur_quant_ids     = '0;
            cur_huff_ids      = '0;
            base_factor0      = '0;
            residual          = 1'b0;
            o_error_count     = 0;
            o_results_checked = 0;
            o_status_seen     = '0;
            expected_results.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) residual = i_cfg_data;
            if (i_out_valid && i_out_ready) check_result(i_out_data);
            if (i_in_valid && i_in_ready) predict_header_byte(i_in_data);
        end
        o_pending_results = expected_results.size();
    end

endmodule

/* dv/tb_jpeg_frame_scan_header_parser.sv */
// Testbench top for the JPEG frame/scan header parser: stimulus, handshakes and verdict.
`timescale 1ns / 1ps

module tb_jpeg_frame_scan_header_parser;
    import jfshp_pkg::*;

    localparam int RANDOM_ITEMS    = 1650;
    localparam int RANDOM_PHASES   = 6;
    localparam int HOLD_OFF_CYCLES = 300;
    // Margin for the block to go quiet after a good frame divide.
    localparam int SETTLE_CYCLES   = 40;
    // Longest correct quiet stretch is the receiver hold-off plus a frame divide.
    localparam int STALL_LIMIT     = 3000;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_in_valid;
    logic         o_in_ready;
    t_header_item i_in_data;
    logic         o_out_valid;
    logic         i_out_ready;
    t_result_item o_out_data;
    logic         i_cfg_valid;
    logic         o_cfg_ready;
    logic         i_cfg_data;

    int         error_count;
    int         pending_results;
    int         results_checked;
    logic [7:0] status_seen;

    bit           idle_on;
    bit           hold_request;
    int           bytes_accepted;
    int           cfg_writes;
    int           stall_cycles;
    t_header_item byte_q[$];

    jpeg_frame_scan_header_parser u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    jfshp_result_checker u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .i_in_ready        (o_in_ready),
        .i_in_data         (i_in_data),
        .i_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .i_out_data        (o_out_data),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_ready       (o_cfg_ready),
        .i_cfg_data        (i_cfg_data),
        .o_error_count     (error_count),
        .o_pending_results (pending_results),
        .o_results_checked (results_checked),
        .o_status_seen     (status_seen)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Receiver: random stalls, with one long hold-off on request.
    initial begin
        bit hold_taken;
        hold_taken  = 1'b0;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request && !hold_taken) begin
                hold_taken = 1'b1;
                i_out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge i_clk);
            end else begin
                i_out_ready <= !idle_on || ($urandom_range(0, 99) >= 23);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("timeout after %0d cycles without a transaction", STALL_LIMIT);
            $display("status: fail");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    function automatic void push_byte(input logic [7:0] b, input logic st, input logic kind);
        t_header_item it;
        it.data_byte     = b;
        it.segment_start = st;
        it.segment_kind  = kind;
        byte_q.push_back(it);
    endfunction

    // Non-start bytes carry a random kind bit, which the block must ignore.
    function automatic void push_body(input logic [7:0] b);
        push_byte(b, 1'b0, 1'($urandom_range(0, 1)));
    endfunction

    // A 0xFF dimension byte is followed by one filler byte, as in the file.
    function automatic void push_dim(input logic [15:0] v);
        push_body(v[15:8]);
        if (v[15:8] == 8'hFF) push_body(8'($urandom));
        push_body(v[7:0]);
        if (v[7:0] == 8'hFF) push_body(8'($urandom));
    endfunction

    function automatic void build_frame(input logic [15:0] h, input logic [15:0] w,
                                        input logic [7:0] nf, input logic [23:0] f,
                                        input logic [23:0] q);
        push_byte(8'($urandom), 1'b1, KIND_FRAME);
        push_body(8'($urandom));
        push_body(8'($urandom));
        push_dim(h);
        push_dim(w);
        push_body(nf);
        for (int c = 0; c < COMPONENTS; c++) begin
            push_body(8'($urandom));
            push_body(f[8*c +: 8]);
            push_body(q[8*c +: 8]);
        end
    endfunction

    function automatic void build_scan(input logic [7:0] ns, input logic [23:0] t);
        push_byte(8'($urandom), 1'b1, KIND_SCAN);
        push_body(8'($urandom));
        push_body(ns);
        for (int c = 0; c < COMPONENTS; c++) begin
            push_body(8'($urandom));
            push_body(t[8*c +: 8]);
        end
        push_body(8'($urandom));
        push_body(8'($urandom));
        push_body(8'($urandom));
    endfunction

    function automatic void build_noise(input int n);
        for (int i = 0; i < n; i++) push_body(8'($urandom));
    endfunction

    function automatic logic [15:0] rand_dim();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35) return 16'($urandom);
        if (r < 65) return 16'($urandom_range(1, 200));
        if (r < 85) return {8'hFF, 8'($urandom)};
        return {8'($urandom), 8'hFF};
    endfunction

    function automatic logic [7:0] rand_count();
        return ($urandom_range(0, 99) < 92) ? 8'(COMPONENTS) : 8'($urandom);
    endfunction

    function automatic logic [7:0] rand_factor();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85) return {4'($urandom_range(1, 4)), 4'($urandom_range(1, 4))};
        if (r < 92) return 8'($urandom);
        return $urandom_range(0, 1) ? {4'h0, 4'($urandom)} : {4'($urandom), 4'h0};
    endfunction

    function automatic logic [7:0] rand_quant();
        return ($urandom_range(0, 99) < 90) ? 8'($urandom_range(0, 1)) : 8'($urandom);
    endfunction

    function automatic logic [7:0] rand_tables();
        if ($urandom_range(0, 99) < 90)
            return {3'b0, 1'($urandom_range(0, 1)), 3'b0, 1'($urandom_range(0, 1))};
        return 8'($urandom);
    endfunction

    // Offers one byte at a falling edge and returns at the falling edge after its transaction.
    task automatic send_item(input t_header_item it);
        while (idle_on && $urandom_range(0, 99) < 23) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        bytes_accepted++;
        @(negedge i_clk);
    endtask

    task automatic send_queued_bytes();
        foreach (byte_q[i]) send_item(byte_q[i]);
        byte_q.delete();
    endtask

    // Register writes happen only with the block drained and quiet.
    task automatic set_residual_layer(input logic v);
        i_in_valid <= 1'b0;
        while (pending_results != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        cfg_writes++;
    endtask

    initial begin
        int phase_items;
        int pick;
        int cut;
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_in_data      = '0;
        i_cfg_valid    = 1'b0;
        i_cfg_data     = 1'b0;
        idle_on        = 1'b1;
        hold_request   = 1'b0;
        bytes_accepted = 0;
        cfg_writes     = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part. A residual frame before any base frame sees a zero factor.
        set_residual_layer(1'b1);
        build_noise(2);
        send_queued_bytes();
        build_frame(16'h0010, 16'h0020, 8'd3, 24'h111111, 24'h000000);
        send_queued_bytes();
        set_residual_layer(1'b0);
        build_frame(16'hFFFF, 16'hFFFF, 8'd3, 24'h111111, 24'h000000);
        build_frame(16'h0000, 16'h0000, 8'd3, 24'h222244, 24'h010101);
        build_frame(16'h0001, 16'h0001, 8'd3, 24'h00FFF1, 24'h000100);
        build_frame(16'h1234, 16'h4321, 8'd2, 24'h111111, 24'h000000);
        build_frame(16'h1234, 16'h4321, 8'hFF, 24'h111111, 24'h000000);
        build_frame(16'h0100, 16'h0200, 8'd3, 24'h111111, 24'h000002);
        build_frame(16'h0100, 16'h0200, 8'd3, 24'h111111, 24'hFF0000);
        build_frame(16'h0100, 16'h0200, 8'd3, 24'h111101, 24'h000000);
        build_frame(16'h0100, 16'h0200, 8'd3, 24'h111110, 24'h000000);
        build_frame(16'h0321, 16'h0457, 8'd3, 24'h111121, 24'h010001);
        build_scan(8'd3, 24'h111111);
        build_scan(8'd3, 24'h000000);
        build_scan(8'd1, 24'h111111);
        build_scan(8'hFF, 24'h111111);
        build_scan(8'd3, 24'h010120);
        build_scan(8'd3, 24'h020101);
        build_scan(8'd3, 24'hFF0000);
        send_queued_bytes();
        // A segment start in the middle of a frame restarts parsing.
        build_frame(16'h0400, 16'h0300, 8'd3, 24'h111122, 24'h000000);
        while (byte_q.size() > 10) void'(byte_q.pop_back());
        build_scan(8'd3, 24'h100110);
        build_noise(3);
        send_queued_bytes();
        set_residual_layer(1'b1);
        build_frame(16'h0080, 16'h00F0, 8'd3, 24'h444433, 24'h010000);
        build_scan(8'd3, 24'h011011);
        send_queued_bytes();

        // Random part: mostly well-formed segments, some cut short, some stray bytes.
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            set_residual_layer(1'(phase % 2));
            idle_on = (phase != 2);
            if (phase == 3) hold_request = 1'b1;
            phase_items = 0;
            while (phase_items < RANDOM_ITEMS / RANDOM_PHASES) begin
                pick = $urandom_range(0, 99);
                if (pick < 90) begin
                    if (pick < 45 || (pick >= 80 && pick < 85)) begin
                        build_frame(rand_dim(), rand_dim(), rand_count(),
                                    {rand_factor(), rand_factor(), rand_factor()},
                                    {rand_quant(), rand_quant(), rand_quant()});
                    end else begin
                        build_scan(rand_count(), {rand_tables(), rand_tables(), rand_tables()});
                    end
                    if (pick >= 80) begin
                        cut = $urandom_range(1, byte_q.size() - 1);
                        while (byte_q.size() > cut) void'(byte_q.pop_back());
                    end
                    phase_items += byte_q.size();
                end else begin
                    build_noise($urandom_range(1, 5));
                end
                send_queued_bytes();
            end
        end

        i_in_valid <= 1'b0;
        while (pending_results != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("summary: %0d header bytes accepted, %0d results checked, %0d layer writes",
                 bytes_accepted, results_checked, cfg_writes);
        $display("summary: result codes seen (bit per code) %05b, one %0d-cycle receiver hold-off",
                 status_seen[4:0], HOLD_OFF_CYCLES);
        if (error_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

/* jpeg_frame_scan_header_parser.f */
sv/jfshp_pkg.sv
sv/jpeg_frame_scan_header_parser.sv
dv/jfshp_result_checker.sv
dv/tb_jpeg_frame_scan_header_parser.sv
